/* rtl/mrb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_pkg: shared types and constants
// Sizes, register map and the structs passed between the rotation buffer parts.
// ----------------------------------------------------------------------------
package mrb_pkg;

  localparam int MAX_DIM     = 64;
  localparam int ELEM_WIDTH  = 32;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = 7;                    // rows/cols register width
  localparam int POS_W       = $clog2(MAX_DIM);      // read_row / read_col
  localparam int CNT_W       = 13;                   // write_count
  localparam int TURN_W      = 2;
  localparam int PADDR_W     = 4;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_TURNS = 2'd2;

  localparam logic [TURN_W-1:0] TURN_QUARTER = 2'd1;
  localparam logic [TURN_W-1:0] TURN_HALF    = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_DATA = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [TURN_W-1:0] quarter_turns;
  } cfg_t;

  // per-item command from the sequencer to the store and output stages
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;       // read result produced this cycle
    logic              use_ram;  // result carries a stored element
    logic [ADDR_W-1:0] raddr;
    logic              status;
    logic              last;
  } req_t;

  // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] res;
    res = d;
    if (d == '0) res = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIM)) res = DIM_W'(MAX_DIM);
    return res;
  endfunction

endpackage

/* rtl/mrb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mrb_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_cfg: configuration registers
// APB-style register file holding rows, cols and quarter_turns.
// ----------------------------------------------------------------------------
module mrb_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output mrb_pkg::cfg_t               cfg
);
  import mrb_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_ROWS:  cfg_nxt.rows          = pwdata[DIM_W-1:0];
        REG_COLS:  cfg_nxt.cols          = pwdata[DIM_W-1:0];
        REG_TURNS: cfg_nxt.quarter_turns = pwdata[TURN_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows          <= DIM_W'(MAX_DIM);
      cfg_r.cols          <= DIM_W'(MAX_DIM);
      cfg_r.quarter_turns <= TURN_HALF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS:  prdata = {{(32-DIM_W){1'b0}}, cfg_r.rows};
      REG_COLS:  prdata = {{(32-DIM_W){1'b0}}, cfg_r.cols};
      REG_TURNS: prdata = {{(32-TURN_W){1'b0}}, cfg_r.quarter_turns};
      default:   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* rtl/mrb_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_seq: frame sequencer
// Write counter, rotated read position and store address generation.
// ----------------------------------------------------------------------------
module mrb_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  mrb_pkg::cfg_t cfg,
  input  logic          acc,
  input  logic          mode,
  output mrb_pkg::req_t req
);
  import mrb_pkg::*;

  logic [CNT_W-1:0] wcnt_r, wcnt_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0] col_r, col_nxt;

  logic [DIM_W-1:0]   r, c, out_rows, out_cols;
  logic [DIM_W-1:0]   row_x, col_x, src_r, src_c;
  logic [2*DIM_W-1:0] size, addr_full;
  logic               quarter, full, stale, at_last_col, is_last;

  always_comb begin
    r        = clamp_dim(cfg.rows);
    c        = clamp_dim(cfg.cols);
    size     = r * c;
    quarter  = (cfg.quarter_turns == TURN_QUARTER);
    out_rows = quarter ? c : r;
    out_cols = quarter ? r : c;
    row_x    = DIM_W'(row_r);
    col_x    = DIM_W'(col_r);
    full     = ({{(2*DIM_W-CNT_W){1'b0}}, wcnt_r} >= size);
    stale    = (row_x >= out_rows) || (col_x >= out_cols);
    if (quarter) begin
      src_r = col_x;
      src_c = c - DIM_W'(1) - row_x;
    end else begin
      src_r = r - DIM_W'(1) - row_x;
      src_c = c - DIM_W'(1) - col_x;
    end
    addr_full   = src_r * c + {{DIM_W{1'b0}}, src_c};
    at_last_col = (col_x == out_cols - DIM_W'(1));
    is_last     = (row_x == out_rows - DIM_W'(1)) && at_last_col;
  end

  always_comb begin
    wcnt_nxt    = wcnt_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    req.we      = 1'b0;
    req.waddr   = wcnt_r[ADDR_W-1:0];
    req.re      = 1'b0;
    req.use_ram = 1'b0;
    req.raddr   = addr_full[ADDR_W-1:0];
    req.status  = STATUS_NO_DATA;
    req.last    = 1'b0;
    if (acc) begin
      if (mode == MODE_WRITE) begin
        if (!full) begin
          req.we   = 1'b1;
          wcnt_nxt = wcnt_r + CNT_W'(1);
        end
      end else begin
        req.re = 1'b1;
        if (full) begin
          if (stale) begin
            wcnt_nxt = '0;
            row_nxt  = '0;
            col_nxt  = '0;
          end else begin
            req.use_ram = 1'b1;
            req.status  = STATUS_OK;
            req.last    = is_last;
            if (is_last) begin
              wcnt_nxt = '0;
              row_nxt  = '0;
              col_nxt  = '0;
            end else if (at_last_col) begin
              col_nxt = '0;
              row_nxt = row_r + POS_W'(1);
            end else begin
              col_nxt = col_r + POS_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      wcnt_r <= wcnt_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

/* rtl/matrix_rotation_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_rotation_buffer: frame buffer with 90/180 degree readout
// Stores a rows-by-cols frame in row-major order and returns it rotated.
// ----------------------------------------------------------------------------
//
//  port group  | dir | carries
//  ------------+-----+---------------------------------------------------
//  in_*        | in  | request: tdata = value, tuser = mode (0 wr, 1 rd)
//  out_*       | out | result: tdata = data_out, tuser = status, tlast
//  cfg_*       | in  | APB regs: 0x0 rows, 0x4 cols, 0x8 quarter_turns
//
//  One request per cycle while in_tready is high, writes and reads alike.
//  A read request is decoded by the sequencer and reads the frame RAM at its
//  acceptance edge into the RAM read stage; with the output register free the
//  data then moves into the output register, which drives out_tvalid.
//  A two-slot path (RAM read stage plus output register) keeps in_tready
//  high while a finished result waits; both slots full and out_tready low
//  stalls the input. Writes produce no result.
//  Synchronous active-low reset clears counters and valids and sets the config
//  registers to their defaults; frame contents are undefined until written, no clearing pass.
//
module matrix_rotation_buffer (
  input  logic                        clk,
  input  logic                        rst_n,
  // input requests
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [31:0] value
  input  logic                        in_tuser,   // [0] mode
  // results
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // [31:0] data_out
  output logic                        out_tuser,  // [0] status
  output logic                        out_tlast,
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mrb_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import mrb_pkg::*;

  cfg_t cfg;
  req_t req;
  logic acc;
  logic [ELEM_WIDTH-1:0] rdata;

  // RAM read stage: result whose data is arriving from the frame RAM
  logic p_valid_r, p_valid_nxt;
  logic p_use_ram_r, p_status_r, p_last_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [ELEM_WIDTH-1:0] out_data_r;
  logic                  out_status_r, out_last_r;
  logic                  out_load;

  mrb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mrb_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .acc   (acc),
    .mode  (in_tuser),
    .req   (req)
  );

  mrb_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (in_tdata[ELEM_WIDTH-1:0]),
    .re    (req.use_ram),
    .raddr (req.raddr),
    .rdata (rdata)
  );

  // the RAM read stage moves on when the output register is free or draining;
  // RAM data holds while it waits since no new read is issued then
  assign out_load  = p_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p_valid_r || out_load;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    if (req.re)        p_valid_nxt = 1'b1;
    else if (out_load) p_valid_nxt = 1'b0;
    else               p_valid_nxt = p_valid_r;

    if (out_load)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      p_use_ram_r <= req.use_ram;
      p_status_r  <= req.status;
      p_last_r    <= req.last;
    end
    if (out_load) begin
      out_data_r   <= p_use_ram_r ? rdata : '0;
      out_status_r <= p_status_r;
      out_last_r   <= p_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 32'(out_data_r);
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
